// File: hdl/tatc_pkg.sv
// Shared types and constants for the thermistor ADC to temperature block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package tatc_pkg;

   // Field widths fixed by the register map and the result format
   localparam int RES_W     = 20;
   localparam int BETA_W    = 13;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int TEMP_W    = 18;

   // log2 unit: Q.30 mantissa, 24 fraction bits
   localparam int MANT_W    = 31;
   localparam int FRAC_BITS = 24;

   // B * 763264000 (= 29815 * 25600) is the quotient numerator before the << 16
   localparam int NUM_W  = BETA_W + 30;
   localparam int BDEN_W = BETA_W + 23;
   localparam int DVD_W  = NUM_W + 16;

   localparam logic [RES_W-1:0]  RS_RESET   = 20'd102000;
   localparam logic [RES_W-1:0]  R0_RESET   = 20'd100000;
   localparam logic [BETA_W-1:0] BETA_RESET = 13'd3950;
   localparam logic [CNT_W-1:0]  CNT_RESET  = 6'd20;

   localparam logic [14:0]        C_KELVIN   = 15'd29815;     // 298.15 * 100
   localparam logic [22:0]        C_BETA_DEN = 23'd6553600;   // 100 * 65536
   localparam logic [29:0]        C_BETA_NUM = 30'd763264000; // 29815 * 25600
   localparam logic signed [32:0] LN2_Q32    = 33'sd2977044472;
   localparam logic [24:0]        Q_SAT      = 25'd20099790;  // first quotient that saturates
   localparam logic [24:0]        Q_BIAS     = 25'd10;
   // ceil(2^32 / 100): exact floor(q / 100) for any 25-bit q
   localparam logic [25:0]        C_RECIP_100 = 26'd42949673;
   localparam int                 RECIP_SHIFT = 32;
   localparam logic signed [18:0] T_OFFSET   = 19'sd69926;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd131071;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERIES  = 2'd0,
      CSR_NOMINAL = 2'd1,
      CSR_BETA    = 2'd2,
      CSR_COUNT   = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCUM,
      OP_AVG_START,
      OP_AVG_TAKE,
      OP_MUL,
      OP_LOGA_START,
      OP_LOGA_TAKE,
      OP_LOGB_START,
      OP_LOGB_TAKE,
      OP_DIFF,
      OP_LNMUL,
      OP_LQ,
      OP_DEN,
      OP_QDIV_START,
      OP_DIV100,
      OP_TEMP_HOT,
      OP_TEMP_TAKE,
      OP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      logic last_sample;
      logic div_done;
      logic log_done;
      logic avg_rail;
      logic den_nonpos;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_AVG_START,
      ST_AVG_RUN,
      ST_MUL,
      ST_LOGA_START,
      ST_LOGA_RUN,
      ST_LOGB_START,
      ST_LOGB_RUN,
      ST_DIFF,
      ST_LNMUL,
      ST_LQ,
      ST_DEN,
      ST_DEN_CHK,
      ST_QDIV_RUN,
      ST_TEMP,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQR
   } log_state_type;

endpackage

// File: hdl/tatc_if.sv
// Channel interfaces: sample request and temperature response.
// Depends on tatc_pkg.
`timescale 1ns / 1ps

interface tatc_req_if #(parameter int ADC_BITS = 10);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] sample_code;

   modport source (output valid, output sample_code, input ready);
   modport sink   (input valid, input sample_code, output ready);
endinterface

interface tatc_rsp_if #(parameter int ADC_BITS = 10);
   logic                                valid;
   logic                                ready;
   logic signed [tatc_pkg::TEMP_W-1:0]  temperature;
   logic [ADC_BITS-1:0]                 average_code;
   logic                                out_of_range;

   modport source (output valid, output temperature, output average_code,
                   output out_of_range, input ready);
   modport sink   (input valid, input temperature, input average_code,
                   input out_of_range, output ready);
endinterface

// File: hdl/thermistor_adc_to_temperature.sv
// Top level: NTC thermistor ADC samples to temperature (beta equation).
// Depends on tatc_pkg, tatc_if, tatc_ctrl, tatc_datapath.
`timescale 1ns / 1ps
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        sample_code[ADC_BITS-1:0]
//  rsp_chan  out  valid/ready        temperature (Q.8 degC), average_code, out_of_range
//  csr_*     in   csr_wr_en only     csr_index (register number), csr_wr_data[19:0]
//
// The sample that completes an average starts a computation: two 59-step passes
// through the shared divider (average, beta quotient), two log2 passes (normalize,
// then 24 squarings each) and a reciprocal multiply for the divide by 100.
// A rail average skips the math. No samples are taken meanwhile.
// Synchronous active-high reset restores the register defaults and clears the
// accumulator. The result sits in an output register, so samples keep flowing
// while rsp_chan is stalled; only the next finished result waits for it.

module thermistor_adc_to_temperature #(
   parameter int ADC_BITS    = 10,
   parameter int MAX_AVERAGE = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   tatc_req_if.sink                           req_chan,
   tatc_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [tatc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tatc_pkg::RES_W-1:0]         csr_wr_data
);
   import tatc_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   // sequencer: one datapath operation per cycle
   tatc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .op        (op),
      .status    (status)
   );

   tatc_datapath #(.ADC_BITS(ADC_BITS), .MAX_AVERAGE(MAX_AVERAGE)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .sample_code  (req_chan.sample_code),
      .temperature  (rsp_chan.temperature),
      .average_code (rsp_chan.average_code),
      .out_of_range (rsp_chan.out_of_range)
   );

endmodule

// File: hdl/tatc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module tatc_div #(
   parameter int DVD_W = 59,
   parameter int DSR_W = 39
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);
   localparam int CNTW = $clog2(DVD_W + 1);

   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   partial;
   logic [DSR_W:0]   diff;
   logic             fits;

   assign partial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = partial - {1'b0, dsr_ff};
   assign fits    = partial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNTW'(DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DSR_W-1:0] : partial[DSR_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: hdl/tatc_log2.sv
// log2 in Q.24 by normalize then repeated squaring, one bit per cycle.
// Depends on tatc_pkg.
`timescale 1ns / 1ps

module tatc_log2 #(
   parameter int NW = 31
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [NW-1:0]                               x,
   output logic [$clog2(NW)+tatc_pkg::FRAC_BITS-1:0]   result,
   output logic                                        done
);
   import tatc_pkg::*;

   localparam int EW  = $clog2(NW);
   localparam int STW = $clog2(FRAC_BITS + 1);

   log_state_type        state_ff, state_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [EW-1:0]        e_ff, e_in;
   logic [MANT_W-1:0]    m_ff, m_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [STW-1:0]       step_ff, step_in;
   logic                 done_ff, done_in;
   logic [2*MANT_W-1:0]  sq;
   logic [MANT_W:0]      sqs;

   assign sq  = m_ff * m_ff;
   assign sqs = sq[2*MANT_W-1 -: MANT_W+1];

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         LOG_IDLE: begin
            if (start) begin
               n_in     = x;
               e_in     = EW'(NW - 1);
               state_in = LOG_NORM;
            end
         end
         LOG_NORM: begin
            if (n_ff[NW-1]) begin
               m_in     = n_ff[NW-1 -: MANT_W];
               frac_in  = '0;
               step_in  = STW'(FRAC_BITS);
               state_in = LOG_SQR;
            end else begin
               n_in = {n_ff[NW-2:0], 1'b0};
               e_in = e_ff - 1'b1;
            end
         end
         LOG_SQR: begin
            // square lands in [1,4); fold back to [1,2) and emit one bit
            if (sqs[MANT_W]) begin
               m_in    = sqs[MANT_W:1];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = sqs[MANT_W-1:0];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STW'(1)) begin
               done_in  = 1'b1;
               state_in = LOG_IDLE;
            end
         end
         default: state_in = LOG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign result = {e_ff, frac_ff};
   assign done   = done_ff;

endmodule

// File: hdl/tatc_datapath.sv
// Datapath: config registers, accumulator, multipliers, shared divider and log2 unit,
// result register. Depends on tatc_pkg, tatc_div, tatc_log2.
`timescale 1ns / 1ps

module tatc_datapath #(
   parameter int ADC_BITS    = 10,
   parameter int MAX_AVERAGE = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tatc_pkg::dp_op_type                 op,
   output tatc_pkg::dp_status_type             status,
   input  logic                                csr_wr_en,
   input  logic [tatc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tatc_pkg::RES_W-1:0]          csr_wr_data,
   input  logic [ADC_BITS-1:0]                 sample_code,
   output logic signed [tatc_pkg::TEMP_W-1:0]  temperature,
   output logic [ADC_BITS-1:0]                 average_code,
   output logic                                out_of_range
);
   import tatc_pkg::*;

   localparam int CW    = $clog2(MAX_AVERAGE + 1);
   localparam int SW    = ADC_BITS + CW;
   localparam int XW    = (CW > CNT_W) ? CW : CNT_W;
   localparam int PW    = RES_W + ADC_BITS;
   localparam int NW    = (PW > MANT_W) ? PW : MANT_W;
   localparam int EW    = $clog2(NW);
   localparam int LOGW  = EW + FRAC_BITS;
   localparam int DW    = LOGW + 1;
   localparam int LPW   = DW + 33;
   localparam int LQW   = LPW - 40;
   localparam int KW    = LQW + 16;
   localparam int DENW  = ((KW > BDEN_W) ? KW : BDEN_W) + 1;
   localparam int DSR_W = DENW - 1;
   localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
   localparam logic [XW-1:0]       MAX_CNT    = XW'(MAX_AVERAGE);

   logic [RES_W-1:0]         rs_ff, rs_in, r0_ff, r0_in;
   logic [BETA_W-1:0]        beta_ff, beta_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]            sum_ff, sum_in;
   logic [CW-1:0]            taken_ff, taken_in;
   logic [ADC_BITS-1:0]      avg_ff, avg_in;
   logic                     flag_ff, flag_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [PW-1:0]            a_ff, a_in, b_ff, b_in;
   logic [NUM_W-1:0]         numer_ff, numer_in;
   logic [BDEN_W-1:0]        bden_ff, bden_in;
   logic [LOGW-1:0]          la_ff, la_in, lb_ff, lb_in;
   logic signed [DW-1:0]     d_ff, d_in;
   logic signed [LPW-1:0]    prod_ff, prod_in;
   logic signed [LQW-1:0]    lq_ff, lq_in;
   logic signed [DENW-1:0]   den_ff, den_in;
   logic [17:0]              q100_ff, q100_in;
   logic signed [TEMP_W-1:0] temp_out_ff, temp_out_in;
   logic [ADC_BITS-1:0]      avg_out_ff, avg_out_in;
   logic                     flag_out_ff, flag_out_in;

   logic [XW-1:0]            cnt_ext, count_eff;
   logic [RES_W-1:0]         rs_eff, r0_eff;
   logic [ADC_BITS-1:0]      comp;
   logic signed [KW-1:0]     kprod;
   logic                     div_start, div_done;
   logic [DVD_W-1:0]         div_dvd, quo;
   logic [DSR_W-1:0]         div_dsr;
   logic [24:0]              q_clip, q_biased;
   logic [50:0]              recip_prod;
   logic signed [18:0]       t_raw;
   logic signed [TEMP_W-1:0] t_sat;
   logic                     log_start, log_done;
   logic [NW-1:0]            log_x;
   logic [LOGW-1:0]          log_res;

   // average count clamped to [1, MAX_AVERAGE]
   assign cnt_ext   = XW'(cnt_ff);
   assign count_eff = (cnt_ext == '0) ? XW'(1) : ((cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext);
   assign rs_eff    = (rs_ff == '0) ? RES_W'(1) : rs_ff;
   assign r0_eff    = (r0_ff == '0) ? RES_W'(1) : r0_ff;
   assign comp      = FULL_SCALE - avg_ff;
   assign kprod     = lq_ff * $signed({1'b0, C_KELVIN});

   // divide by 100 as a reciprocal multiply
   assign q_clip     = (quo >= DVD_W'(Q_SAT)) ? Q_SAT : quo[24:0];
   assign q_biased   = q_clip + Q_BIAS;
   assign recip_prod = q_biased * C_RECIP_100;
   assign t_raw      = $signed({1'b0, q100_ff}) - T_OFFSET;
   assign t_sat      = (t_raw > 19'(TEMP_MAX)) ? TEMP_MAX : t_raw[TEMP_W-1:0];

   assign div_start = (op == OP_AVG_START) || (op == OP_QDIV_START);
   always_comb begin
      case (op)
         OP_QDIV_START: begin
            div_dvd = {numer_ff, 16'b0};
            div_dsr = den_ff[DSR_W-1:0];
         end
         default: begin
            div_dvd = DVD_W'(sum_ff);
            div_dsr = DSR_W'(taken_ff);
         end
      endcase
   end

   assign log_start = (op == OP_LOGA_START) || (op == OP_LOGB_START);
   assign log_x     = (op == OP_LOGA_START) ? NW'(a_ff) : NW'(b_ff);

   tatc_div #(.DVD_W(DVD_W), .DSR_W(DSR_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (quo),
      .done     (div_done)
   );

   tatc_log2 #(.NW(NW)) u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .result (log_res),
      .done   (log_done)
   );

   always_comb begin
      rs_in       = rs_ff;
      r0_in       = r0_ff;
      beta_in     = beta_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      taken_in    = taken_ff;
      avg_in      = avg_ff;
      flag_in     = flag_ff;
      temp_in     = temp_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      numer_in    = numer_ff;
      bden_in     = bden_ff;
      la_in       = la_ff;
      lb_in       = lb_ff;
      d_in        = d_ff;
      prod_in     = prod_ff;
      lq_in       = lq_ff;
      den_in      = den_ff;
      q100_in     = q100_ff;
      temp_out_in = temp_out_ff;
      avg_out_in  = avg_out_ff;
      flag_out_in = flag_out_ff;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SERIES:  rs_in   = csr_wr_data;
            CSR_NOMINAL: r0_in   = csr_wr_data;
            CSR_BETA:    beta_in = csr_wr_data[BETA_W-1:0];
            CSR_COUNT:   cnt_in  = csr_wr_data[CNT_W-1:0];
         endcase
      end

      case (op)
         OP_ACCUM: begin
            sum_in   = sum_ff + SW'(sample_code);
            taken_in = taken_ff + 1'b1;
         end
         OP_AVG_START: begin
            sum_in   = '0;
            taken_in = '0;
         end
         OP_AVG_TAKE: begin
            avg_in  = quo[ADC_BITS-1:0];
            flag_in = status.avg_rail;
            temp_in = '0;
         end
         OP_MUL: begin
            a_in     = rs_eff * avg_ff;
            b_in     = comp * r0_eff;
            numer_in = beta_ff * C_BETA_NUM;
            bden_in  = beta_ff * C_BETA_DEN;
         end
         OP_LOGA_TAKE: la_in = log_res;
         OP_LOGB_TAKE: lb_in = log_res;
         OP_DIFF:      d_in  = $signed({1'b0, la_ff}) - $signed({1'b0, lb_ff});
         OP_LNMUL:     prod_in = d_ff * LN2_Q32;
         // floor((p + 2^39) / 2^40): the half bit rounds up
         OP_LQ:        lq_in = prod_ff[LPW-1:40] + LQW'(prod_ff[39]);
         OP_DEN:       den_in = DENW'(kprod) + DENW'(bden_ff);
         OP_DIV100:    q100_in = recip_prod[RECIP_SHIFT+17:RECIP_SHIFT];
         OP_TEMP_HOT:  temp_in = TEMP_MAX;
         OP_TEMP_TAKE: temp_in = t_sat;
         OP_LOAD_OUT: begin
            temp_out_in = temp_ff;
            avg_out_in  = avg_ff;
            flag_out_in = flag_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff    <= RS_RESET;
         r0_ff    <= R0_RESET;
         beta_ff  <= BETA_RESET;
         cnt_ff   <= CNT_RESET;
         sum_ff   <= '0;
         taken_ff <= '0;
      end else begin
         rs_ff    <= rs_in;
         r0_ff    <= r0_in;
         beta_ff  <= beta_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      flag_ff     <= flag_in;
      temp_ff     <= temp_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      numer_ff    <= numer_in;
      bden_ff     <= bden_in;
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      lq_ff       <= lq_in;
      den_ff      <= den_in;
      q100_ff     <= q100_in;
      temp_out_ff <= temp_out_in;
      avg_out_ff  <= avg_out_in;
      flag_out_ff <= flag_out_in;
   end

   assign status.last_sample = ((XW+1)'(taken_ff) + 1'b1) >= (XW+1)'(count_eff);
   assign status.div_done    = div_done;
   assign status.log_done    = log_done;
   assign status.avg_rail    = (quo[ADC_BITS-1:0] == '0) || (quo[ADC_BITS-1:0] == FULL_SCALE);
   assign status.den_nonpos  = den_ff[DENW-1] || (den_ff == '0);

   assign temperature  = temp_out_ff;
   assign average_code = avg_out_ff;
   assign out_of_range = flag_out_ff;

endmodule

// File: hdl/tatc_ctrl.sv
// Controller FSM: sequences the datapath and owns the channel handshakes.
// Depends on tatc_pkg.
`timescale 1ns / 1ps

module tatc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tatc_pkg::dp_op_type     op,
   input  tatc_pkg::dp_status_type status
);
   import tatc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op           = OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_ACCUM;
               if (status.last_sample) begin
                  state_in = ST_AVG_START;
               end
            end
         end
         ST_AVG_START: begin
            op       = OP_AVG_START;
            state_in = ST_AVG_RUN;
         end
         ST_AVG_RUN: begin
            if (status.div_done) begin
               op       = OP_AVG_TAKE;
               state_in = status.avg_rail ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            op       = OP_MUL;
            state_in = ST_LOGA_START;
         end
         ST_LOGA_START: begin
            op       = OP_LOGA_START;
            state_in = ST_LOGA_RUN;
         end
         ST_LOGA_RUN: begin
            if (status.log_done) begin
               op       = OP_LOGA_TAKE;
               state_in = ST_LOGB_START;
            end
         end
         ST_LOGB_START: begin
            op       = OP_LOGB_START;
            state_in = ST_LOGB_RUN;
         end
         ST_LOGB_RUN: begin
            if (status.log_done) begin
               op       = OP_LOGB_TAKE;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            op       = OP_DIFF;
            state_in = ST_LNMUL;
         end
         ST_LNMUL: begin
            op       = OP_LNMUL;
            state_in = ST_LQ;
         end
         ST_LQ: begin
            op       = OP_LQ;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            op       = OP_DEN;
            state_in = ST_DEN_CHK;
         end
         ST_DEN_CHK: begin
            if (status.den_nonpos) begin
               op       = OP_TEMP_HOT;
               state_in = ST_OUT;
            end else begin
               op       = OP_QDIV_START;
               state_in = ST_QDIV_RUN;
            end
         end
         ST_QDIV_RUN: begin
            if (status.div_done) begin
               op       = OP_DIV100;
               state_in = ST_TEMP;
            end
         end
         ST_TEMP: begin
            op       = OP_TEMP_TAKE;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = OP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
